### rtl/first_fit_block_allocator_unit_macros.svh
// Assertion macros of the first-fit block allocator RTL.
// No dependencies; the asserting file must provide clk and rst_n.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define FFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FFB_ASSERT_SAME(label, ante, cons, msg)

`define FFB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/ffb_pkg.sv
// Shared types, constants and helpers of the first-fit block allocator.
// No dependencies; used by the controller, the datapath and the top level.
package ffb_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 512;
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = 32;
  localparam int ENTRY_W     = CNT_W + 1;
  localparam int NEED_W      = ADDR_W + 1 - BLK_SHIFT;
  localparam int IDXF_W      = ADDR_W - BLK_SHIFT;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 32;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST   = 32'h0020_0000;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = CNT_W'(1024);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE   = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_TOO_FEW   = 3'd2,
    ST_NO_RUN    = 3'd3,
    ST_NULL_FREE = 3'd4,
    ST_OUTSIDE   = 3'd5,
    ST_NOT_USED  = 3'd6
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    clear;
    logic    scan_init;
    logic    scan_step;
    logic    claim_step;
    logic    free_init;
    logic    walk_step;
    logic    respond;
    status_t code;
  } ffb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reinit;
    logic clear_last;
    logic zero_size;
    logic too_few;
    logic pool_empty;
    logic null_addr;
    logic outside;
    logic scan_end;
    logic scan_hit;
    logic claim_last;
    logic blk_used;
    logic walk_done;
  } ffb_stat_t;

  // Usable block count: the register value capped at the pool capacity.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : c;
  endfunction

endpackage

### rtl/ffb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ffb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ffb_dpath.sv
// Datapath of the first-fit block allocator: block table RAM, scan, claim
// and release counters, configuration and result registers. Uses ffb_pkg, ffb_ram.
module ffb_dpath
  import ffb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_op,
  input  logic [ADDR_W-1:0]    in_byte_count,
  input  logic [ADDR_W-1:0]    in_address,
  input  ffb_cmd_t             cmd,
  output ffb_stat_t            stat,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [ADDR_W-1:0]    out_result_address,
  output logic [CNT_W-1:0]     out_free_blocks
);

  // Configuration and counts.
  logic [ADDR_W-1:0] pool_base_r;
  logic [CNT_W-1:0]  block_count_r;
  logic [CNT_W-1:0]  free_total_r;
  logic [IDX_W-1:0]  clr_r;
  logic [CNT_W-1:0]  n_eff;
  logic              reinit;

  // Latched request.
  logic              op_r;
  logic              zero_r;
  logic              null_r;
  logic [NEED_W-1:0] need_r;
  logic [IDXF_W-1:0] idx_r;

  // Scan, claim and release state.
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] run_r;
  logic [CNT_W-1:0] start_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] rel_r;

  // Result registers.
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CNT_W-1:0]  out_free_r;

  // RAM port signals.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               rd_used;
  logic [CNT_W-1:0]   rd_len;

  // Combinational next values.
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] i_nxt;
  logic [CNT_W-1:0] run_nxt;
  logic [CNT_W-1:0] start_nxt;
  logic [CNT_W-1:0] eff_len;
  logic             walk_act;
  logic [CNT_W-1:0] rel_nxt;
  logic [CNT_W:0]   free_sum;
  logic [CNT_W-1:0] free_new;
  logic [ADDR_W-1:0] alloc_addr;

  assign n_eff  = eff_count(block_count_r);
  assign reinit = cfg_we && (cfg_index == REG_BLOCK_COUNT);

  assign rd_used = ram_rdata[CNT_W];
  assign rd_len  = ram_rdata[CNT_W-1:0];

  // One scan step over the block whose entry is on the read port. A used
  // block jumps the whole run; a used block without length is stepped past.
  always_comb begin
    step = (rd_len == '0) ? CNT_W'(1) : rd_len;
    rem  = n_eff - i_r;
    if (rd_used) begin
      i_nxt     = (step >= rem) ? n_eff : CNT_W'(i_r + step);
      run_nxt   = '0;
      start_nxt = i_nxt;
    end else begin
      i_nxt     = CNT_W'(i_r + 1'b1);
      run_nxt   = CNT_W'(run_r + 1'b1);
      start_nxt = start_r;
    end
  end

  // Release walk; the run length comes from the head entry on the first beat.
  assign eff_len  = (k_r == '0) ? rd_len : len_r;
  assign walk_act = (k_r < eff_len) && (j_r < n_eff);
  assign rel_nxt  = (cmd.walk_step && walk_act && rd_used) ? CNT_W'(rel_r + 1'b1) : rel_r;

  assign free_sum   = {1'b0, free_total_r} + {1'b0, rel_nxt};
  assign alloc_addr = pool_base_r + (ADDR_W'(start_r) << BLK_SHIFT);

  always_comb begin
    free_new = free_total_r;
    if (cmd.code == ST_OK) begin
      if (op_r == OP_ALLOC) begin
        free_new = free_total_r - run_r;
      end else begin
        free_new = free_sum[CNT_W] ? '1 : free_sum[CNT_W-1:0];
      end
    end
  end

  // RAM write and read address selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_we = 1'b1;
    end else if (cmd.claim_step) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(start_r[IDX_W-1:0] + k_r[IDX_W-1:0]);
      ram_wdata = {1'b1, (k_r == '0) ? run_r : CNT_W'(0)};
    end else if (cmd.walk_step && walk_act) begin
      ram_we    = 1'b1;
      ram_waddr = j_r[IDX_W-1:0];
    end
  end

  always_comb begin
    ram_raddr = '0;
    if (cmd.scan_step) begin
      ram_raddr = i_nxt[IDX_W-1:0];
    end else if (cmd.free_init) begin
      ram_raddr = idx_r[IDX_W-1:0];
    end else if (cmd.walk_step) begin
      ram_raddr = IDX_W'(j_r[IDX_W-1:0] + 1'b1);
    end
  end

  ffb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= POOL_BASE_RST;
      block_count_r <= BLOCK_COUNT_RST;
      free_total_r  <= eff_count(BLOCK_COUNT_RST);
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
      if (cfg_we && (cfg_index == REG_POOL_BASE)) begin
        pool_base_r <= cfg_wdata;
      end
      if (reinit) begin
        block_count_r <= cfg_wdata[CNT_W-1:0];
        free_total_r  <= eff_count(cfg_wdata[CNT_W-1:0]);
        clr_r         <= '0;
      end else begin
        if (cmd.clear) begin
          clr_r <= IDX_W'(clr_r + 1'b1);
        end
        if (cmd.respond) begin
          free_total_r <= free_new;
        end
      end
    end
  end

  // Request, scan, claim, walk and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      zero_r <= (in_byte_count == '0);
      null_r <= (in_address == '0);
      need_r <= NEED_W'((33'(in_byte_count) + 33'(BLOCK_BYTES - 1)) >> BLK_SHIFT);
      idx_r  <= IDXF_W'((in_address - pool_base_r) >> BLK_SHIFT);
    end
    if (cmd.scan_init) begin
      i_r     <= '0;
      run_r   <= '0;
      start_r <= '0;
      k_r     <= '0;
    end
    if (cmd.scan_step) begin
      i_r     <= i_nxt;
      run_r   <= run_nxt;
      start_r <= start_nxt;
    end
    if (cmd.claim_step) begin
      k_r <= CNT_W'(k_r + 1'b1);
    end
    if (cmd.free_init) begin
      j_r   <= idx_r[CNT_W-1:0];
      k_r   <= '0;
      rel_r <= '0;
    end
    if (cmd.walk_step) begin
      if (k_r == '0) begin
        len_r <= rd_len;
      end
      rel_r <= rel_nxt;
      if (walk_act) begin
        j_r <= CNT_W'(j_r + 1'b1);
        k_r <= CNT_W'(k_r + 1'b1);
      end
    end
    if (cmd.respond) begin
      out_status_r <= cmd.code;
      out_addr_r   <= ((cmd.code == ST_OK) && (op_r == OP_ALLOC)) ? alloc_addr : '0;
      out_free_r   <= free_new;
    end
  end

  always_comb begin
    stat            = '0;
    stat.reinit     = reinit;
    stat.clear_last = (clr_r == '1);
    stat.zero_size  = zero_r;
    stat.too_few    = NEED_W'(free_total_r) < need_r;
    stat.pool_empty = (n_eff == '0);
    stat.null_addr  = null_r;
    stat.outside    = idx_r >= IDXF_W'(n_eff);
    stat.scan_hit   = NEED_W'(run_nxt) >= need_r;
    stat.scan_end   = stat.scan_hit || (i_nxt >= n_eff);
    stat.claim_last = (CNT_W'(k_r + 1'b1) == run_r);
    stat.blk_used   = rd_used;
    stat.walk_done  = !walk_act || (CNT_W'(k_r + 1'b1) >= eff_len)
                      || (CNT_W'(j_r + 1'b1) >= n_eff);
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_free_blocks    = out_free_r;

endmodule

### rtl/ffb_ctrl.sv
// Controller of the first-fit block allocator: sequences table clearing,
// allocate scans, claims and releases. Uses ffb_pkg.
module ffb_ctrl
  import ffb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_op,
  input  ffb_stat_t stat,
  output ffb_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHK,
    S_SCAN,
    S_CLAIM,
    S_FCHK,
    S_FLOOK,
    S_FWALK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    cmd.code  = ST_OK;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_FREE) ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        state_nxt = S_IDLE;
        if (stat.zero_size) begin
          cmd.respond = 1'b1;
          cmd.code    = ST_ZERO_SIZE;
        end else if (stat.too_few) begin
          cmd.respond = 1'b1;
          cmd.code    = ST_TOO_FEW;
        end else if (stat.pool_empty) begin
          cmd.respond = 1'b1;
          cmd.code    = ST_NO_RUN;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          if (stat.scan_hit) begin
            state_nxt = S_CLAIM;
          end else begin
            cmd.respond = 1'b1;
            cmd.code    = ST_NO_RUN;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_CLAIM: begin
        cmd.claim_step = 1'b1;
        if (stat.claim_last) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_FCHK: begin
        state_nxt = S_IDLE;
        if (stat.null_addr) begin
          cmd.respond = 1'b1;
          cmd.code    = ST_NULL_FREE;
        end else if (stat.outside) begin
          cmd.respond = 1'b1;
          cmd.code    = ST_OUTSIDE;
        end else begin
          cmd.free_init = 1'b1;
          state_nxt     = S_FLOOK;
        end
      end
      S_FLOOK: begin
        if (!stat.blk_used) begin
          cmd.respond = 1'b1;
          cmd.code    = ST_NOT_USED;
          state_nxt   = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
          if (stat.walk_done) begin
            cmd.respond = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_FWALK;
          end
        end
      end
      S_FWALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // A block count write restarts the table clear.
    if (stat.reinit) begin
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### rtl/first_fit_block_allocator_unit.sv
// First-fit allocator of 512-byte blocks. After reset and after every write to
// block_count the block table is cleared in one pass with busy high. A request is
// taken when start is high and busy is low. An allocate is first checked and is
// answered at once if rejected; else the scan visits blocks until a run fits or the
// pool ends, and the run's blocks are claimed. A free is checked for a null or an
// outside address, then its table entry is looked up and the release walks the run.
// The table RAM gives one entry per cycle. Each result is shown for exactly one
// cycle with out_valid high and cannot be held off by the receiver. Depends on
// ffb_pkg, ffb_ctrl, ffb_dpath and the assertion macro header.
`include "first_fit_block_allocator_unit_macros.svh"

module first_fit_block_allocator_unit
  import ffb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [ADDR_W-1:0]    in_byte_count,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [ADDR_W-1:0]    out_result_address,
  output logic [CNT_W-1:0]     out_free_blocks,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ffb_cmd_t  cmd;
  ffb_stat_t stat;

  ffb_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .in_op(in_op),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  ffb_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_byte_count     (in_byte_count),
    .in_address        (in_address),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_address(out_result_address),
    .out_free_blocks   (out_free_blocks)
  );

  // An accepted beat must keep the block busy until its result is out.
  `FFB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  // A request yields at most one result, so strobes never come back to back.
  `FFB_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe in consecutive cycles")
  // Only a successful allocate carries an address.
  `FFB_ASSERT_SAME(a_fail_no_addr, out_valid && (out_status != ST_OK), out_result_address == '0, "failed request returned an address")
  // The free count can never exceed the pool capacity.
  `FFB_ASSERT_SAME(a_free_bound, out_valid, out_free_blocks <= CNT_W'(MAX_BLOCKS), "free count above pool capacity")

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for first_fit_block_allocator_unit: directed and random
// allocate/free requests, each reply checked against an in-bench block table.
// Depends on ffb_pkg and the allocator RTL; reads no files.
module tb_top;
  import ffb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned CNT_SAT     = 2047;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] bytes;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  free_cnt;
  } reply_t;

  typedef struct {
    int unsigned head;
    int unsigned len;
  } live_run_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_op = OP_ALLOC;
  logic [ADDR_W-1:0]    in_byte_count = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [ADDR_W-1:0]    out_result_address;
  logic [CNT_W-1:0]     out_free_blocks;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_POOL_BASE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow of the block table and registers.
  bit                blk_used [MAX_BLOCKS];
  int unsigned       blk_run  [MAX_BLOCKS];
  int unsigned       free_total;
  logic [ADDR_W-1:0] base_reg;
  logic [CNT_W-1:0]  count_reg;
  live_run_t         live_runs[$];

  request_t    queued_requests[$];
  reply_t      awaited_replies[$];
  request_t    cur_req;
  reply_t      want;
  bit          beat_taken;
  int          burst_left;
  int          gap_left;
  int          n_requests;
  int          n_checked;
  int          n_errors;
  int          n_settings;
  int          status_hits[7];
  int unsigned cycle_count;

  first_fit_block_allocator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_byte_count      (in_byte_count),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_free_blocks    (out_free_blocks),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int unsigned pool_blocks();
    return (count_reg > CNT_W'(MAX_BLOCKS)) ? MAX_BLOCKS : int'(count_reg);
  endfunction

  function automatic void clear_pool();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_used[k] = 1'b0;
      blk_run[k]  = 0;
    end
    free_total = pool_blocks();
    live_runs.delete();
  endfunction

  // First-fit scan from block 0; used runs are skipped by their recorded length.
  function automatic status_t claim_run(input logic [ADDR_W-1:0] bytes,
                                        output logic [ADDR_W-1:0] run_addr);
    longint unsigned need;
    int unsigned     n, i, head, run, hop;
    run_addr = '0;
    n    = pool_blocks();
    i    = 0;
    head = 0;
    run  = 0;
    if (bytes == 0) return ST_ZERO_SIZE;
    need = ({32'd0, bytes} + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (free_total < need) return ST_TOO_FEW;
    while (i < n && run < need) begin
      if (blk_used[i]) begin
        hop  = (blk_run[i] == 0) ? 1 : blk_run[i];
        i    = (hop >= n - i) ? n : i + hop;
        head = i;
        run  = 0;
      end else begin
        run++;
        i++;
      end
    end
    if (run < need) return ST_NO_RUN;
    for (int unsigned k = 0; k < run; k++) begin
      blk_used[head + k] = 1'b1;
      blk_run[head + k]  = 0;
    end
    blk_run[head] = run;
    free_total -= run;
    run_addr = base_reg + head * BLOCK_BYTES;
    live_runs.push_back('{head: head, len: run});
    return ST_OK;
  endfunction

  function automatic status_t release_run(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] offset;
    int unsigned       n, idx, len, freed;
    n     = pool_blocks();
    freed = 0;
    if (addr == 0) return ST_NULL_FREE;
    offset = addr - base_reg;
    idx    = offset / BLOCK_BYTES;
    if (idx >= n) return ST_OUTSIDE;
    if (!blk_used[idx]) return ST_NOT_USED;
    // A block inside a run carries length 0, so nothing is released there.
    len = blk_run[idx];
    for (int unsigned k = 0; k < len && idx + k < n; k++) begin
      if (blk_used[idx + k]) freed++;
      blk_used[idx + k] = 1'b0;
      blk_run[idx + k]  = 0;
    end
    free_total = (free_total + freed > CNT_SAT) ? CNT_SAT : free_total + freed;
    if (len != 0) begin
      for (int j = live_runs.size() - 1; j >= 0; j--)
        if (live_runs[j].head == idx) live_runs.delete(j);
    end
    return ST_OK;
  endfunction

  function automatic reply_t allocator_reply(request_t rq);
    reply_t rp;
    rp.addr = '0;
    if (rq.op == OP_FREE) rp.status = release_run(rq.addr);
    else rp.status = claim_run(rq.bytes, rp.addr);
    rp.free_cnt = free_total[CNT_W-1:0];
    return rp;
  endfunction

  // Mostly frees of live runs and allocations that fit, with a share of
  // malformed requests mixed in.
  function automatic request_t random_request(int unsigned max_blk);
    request_t    rq;
    live_run_t   pick;
    int unsigned n, sel, blocks, slot;
    n        = pool_blocks();
    sel      = $urandom_range(0, 99);
    rq.bytes = $urandom;
    rq.addr  = $urandom;
    if ($urandom_range(0, 99) < ((live_runs.size() < 3) ? 70 : 50)) begin
      rq.op = OP_ALLOC;
      if (sel < 74) begin
        blocks   = $urandom_range(1, max_blk);
        rq.bytes = (blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
      end else if (sel < 79) begin
        rq.bytes = '0;
      end else if (sel >= 87 && sel < 94) begin
        rq.bytes = $urandom_range(1, n) * BLOCK_BYTES;
      end else if (sel >= 94) begin
        rq.bytes = $urandom_range(1, 32'h0010_0000);
      end
    end else begin
      rq.op = OP_FREE;
      if (sel < 72 && live_runs.size() > 0) begin
        pick    = live_runs[$urandom_range(0, live_runs.size() - 1)];
        slot    = (sel >= 62 && pick.len > 1) ? $urandom_range(1, pick.len - 1) : 0;
        rq.addr = base_reg + (pick.head + slot) * BLOCK_BYTES;
        if ($urandom_range(0, 3) == 0) rq.addr += $urandom_range(1, BLOCK_BYTES - 1);
      end else if (sel < 77) begin
        rq.addr = '0;
      end else if (sel < 82) begin
        rq.addr = base_reg + $urandom_range(n, n + 64) * BLOCK_BYTES;
      end else if (sel < 86) begin
        rq.addr = base_reg - $urandom_range(1, 32'h0010_0000);
      end else if (sel < 94) begin
        rq.addr = base_reg + $urandom_range(0, n * BLOCK_BYTES - 1);
      end
    end
    return rq;
  endfunction

  function automatic void add_request(logic op, logic [ADDR_W-1:0] bytes,
                                      logic [ADDR_W-1:0] addr);
    queued_requests.push_back('{op, bytes, addr});
  endfunction

  function automatic void flag_field(string what, logic [ADDR_W-1:0] exp_val,
                                     logic [ADDR_W-1:0] act_val);
    if (act_val !== exp_val) begin
      n_errors++;
      if (n_errors <= 40)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_val, act_val);
    end
  endfunction

  // Returns at a rising edge once every queued request has been taken.
  task automatic wait_accepted();
    do @(posedge clk); while (queued_requests.size() != 0 || start);
  endtask

  task automatic wait_quiet();
    wait_accepted();
    do @(negedge clk); while (awaited_replies.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // The table is cleared after reset and after a block_count write.
  task automatic wait_clear();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_POOL_BASE) begin
      base_reg = value;
    end else begin
      count_reg = value[CNT_W-1:0];
      clear_pool();
    end
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
  endtask

  task automatic set_pool(logic [ADDR_W-1:0] base, int unsigned count, bit with_count);
    write_reg(REG_POOL_BASE, base);
    if (with_count) write_reg(REG_BLOCK_COUNT, count);
    wait_clear();
    n_settings++;
  endtask

  task automatic run_random(int n_items, int unsigned max_blk);
    int left;
    int batch;
    left = n_items;
    @(posedge clk);
    while (left > 0) begin
      batch = $urandom_range(1, 6);
      if (batch > left) batch = left;
      repeat (batch) queued_requests.push_back(random_request(max_blk));
      left -= batch;
      wait_accepted();
    end
    wait_quiet();
  endtask

  // Prediction happens when the beat is taken.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      awaited_replies.push_back(allocator_reply(cur_req));
      n_requests++;
      beat_taken = 1'b1;
    end
  end

  // Sender: bursts of beats with random gaps; fields are scrambled during gaps.
  always @(negedge clk) begin
    if (!start || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start         <= 1'b0;
        in_op         <= $urandom_range(0, 1);
        in_byte_count <= $urandom;
        in_address    <= $urandom;
      end else if (queued_requests.size() > 0) begin
        cur_req = queued_requests.pop_front();
        start         <= 1'b1;
        in_op         <= cur_req.op;
        in_byte_count <= cur_req.bytes;
        in_address    <= cur_req.addr;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 9);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(20, 60);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected, status %0d address %h",
                 $time, out_status, out_result_address);
      end else begin
        want = awaited_replies.pop_front();
        n_checked++;
        status_hits[int'(want.status)]++;
        flag_field("status", want.status, out_status);
        flag_field("result_address", want.addr, out_result_address);
        flag_field("free_blocks", want.free_cnt, out_free_blocks);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d replies outstanding", $time, awaited_replies.size());
      $display("** first_fit_block_allocator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    base_reg  = POOL_BASE_RST;
    count_reg = BLOCK_COUNT_RST;
    clear_pool();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_clear();

    // Full pool at the default base: every status but no run, and the whole-pool grab.
    set_pool(POOL_BASE_RST, MAX_BLOCKS, 1'b1);
    add_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    add_request(OP_ALLOC, 32'd1, 32'd0);
    add_request(OP_ALLOC, 32'd513, 32'd0);
    add_request(OP_ALLOC, 32'd512, 32'd0);
    add_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    add_request(OP_ALLOC, 32'h0008_0001, 32'd0);
    add_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST - 1);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST + MAX_BLOCKS * BLOCK_BYTES);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST + 4 * BLOCK_BYTES);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST + 2 * BLOCK_BYTES);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST + BLOCK_BYTES + 100);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST + 4 * BLOCK_BYTES - 1);
    add_request(OP_ALLOC, MAX_BLOCKS * BLOCK_BYTES, 32'd0);
    add_request(OP_ALLOC, 32'd1, 32'd0);
    add_request(OP_FREE, 32'd0, POOL_BASE_RST);
    wait_quiet();

    // Four blocks at base 0: last block taken, block 0 cannot be freed,
    // and two free blocks that are not adjacent.
    set_pool(32'd0, 4, 1'b1);
    repeat (4) add_request(OP_ALLOC, 32'd512, 32'd0);
    add_request(OP_FREE, 32'd0, 32'd0);
    add_request(OP_FREE, 32'd0, 32'd512);
    add_request(OP_FREE, 32'd0, 32'd1536);
    add_request(OP_ALLOC, 32'd1024, 32'd0);
    add_request(OP_ALLOC, 32'd1025, 32'd0);
    wait_quiet();

    set_pool(32'h0020_0000, 1024, 1'b1);
    run_random(150, 24);
    // Base moves while runs are live.
    set_pool(32'h1234_5678, 0, 1'b0);
    run_random(60, 24);
    set_pool(32'hFFFF_FF00, 37, 1'b1);
    run_random(80, 8);
    set_pool(32'h0000_0000, 16, 1'b1);
    run_random(80, 6);
    set_pool(32'hA5A5_0000, 1, 1'b1);
    run_random(30, 2);
    set_pool(32'h5A5A_5E00, 1023, 1'b1);
    run_random(100, 64);
    set_pool(32'hFFFF_FFFF, 2, 1'b1);
    run_random(30, 3);
    set_pool(32'h0000_0200, 1024, 1'b1);
    run_random(50, 300);

    repeat (40) @(posedge clk);
    $display("Ran %0d requests over %0d pool settings; %0d replies checked.",
             n_requests, n_settings, n_checked);
    $display("Replies: ok %0d, zero size %0d, too few %0d, no run %0d, null %0d, outside %0d, not used %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6]);
    if (n_errors == 0) begin
      $display("** first_fit_block_allocator_unit: PASSED **");
    end else begin
      $display("** first_fit_block_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### first_fit_block_allocator_unit.f
+incdir+rtl
rtl/ffb_pkg.sv
rtl/ffb_ram.sv
rtl/ffb_dpath.sv
rtl/ffb_ctrl.sv
rtl/first_fit_block_allocator_unit.sv
bench/tb_top.sv
